>>> hw/rtl/dtc_pkg.sv
package dtc_pkg;

  // field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int COUNT_W = 40;
  localparam int DIV_W   = 32;

  // internal widths: day number, year term, tick value (all non-negative)
  localparam int DAYN_W  = 23;
  localparam int TICK_W  = 39;
  localparam int MTERM_W = 9;

  localparam logic [31:0] YEAR_MULT   = 32'd146097;    // days in 400 years
  localparam logic [27:0] RECIP_25    = 28'd171798692; // ceil(2^32 / 25)
  localparam int          RECIP_SHIFT = 32;
  localparam logic [DAYN_W-1:0] YT_NEG_ONE = DAYN_W'(366); // magnitude of the year term of yy = -1

  localparam logic [TICK_W-1:0] HOURS_PER_DAY   = TICK_W'(24);
  localparam logic [TICK_W-1:0] MINS_PER_HOUR   = TICK_W'(60);
  localparam logic [TICK_W-1:0] SECS_PER_MINUTE = TICK_W'(60);

  // (153*mm + 8) / 5, with months 0..2 taken as 12..14
  localparam logic [MTERM_W-1:0] MONTH_TERM [16] = '{
    9'd368, 9'd399, 9'd430, 9'd93,  9'd124, 9'd154, 9'd185, 9'd215,
    9'd246, 9'd277, 9'd307, 9'd338, 9'd368, 9'd399, 9'd430, 9'd460
  };

  typedef enum logic [1:0] {
    UNIT_SEC  = 2'd0,
    UNIT_MIN  = 2'd1,
    UNIT_HOUR = 2'd2,
    UNIT_DAY  = 2'd3
  } unit_t;

  typedef enum logic [2:0] {
    REG_UNIT         = 3'd0,
    REG_DIVISOR      = 3'd1,
    REG_START_YEAR   = 3'd2,
    REG_START_MONTH  = 3'd3,
    REG_START_DAY    = 3'd4,
    REG_START_HOUR   = 3'd5,
    REG_START_MINUTE = 3'd6,
    REG_START_SECOND = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } stamp_t;

endpackage

>>> hw/rtl/dtc_ticks.sv
module dtc_ticks (
  input  logic                      clk,
  input  logic                      en,
  input  dtc_pkg::unit_t            unit,
  input  dtc_pkg::stamp_t           stamp,
  output logic [dtc_pkg::TICK_W-1:0] ticks
);
  import dtc_pkg::*;

  // S1: month shift, day fix, month term
  logic               month_lo;
  logic               s1_neg;
  logic [YEAR_W-1:0]  s1_yy;
  logic [MTERM_W-1:0] s1_mterm;
  logic [DAY_W-1:0]   s1_dd;
  logic [HOUR_W-1:0]  s1_hour;
  logic [MIN_W-1:0]   s1_minute;
  logic [SEC_W-1:0]   s1_second;
  // S2: 146097 * yy
  logic               s2_neg;
  logic [31:0]        s2_n;
  logic [MTERM_W-1:0] s2_mterm;
  logic [DAY_W-1:0]   s2_dd;
  logic [HOUR_W-1:0]  s2_hour;
  logic [MIN_W-1:0]   s2_minute;
  logic [SEC_W-1:0]   s2_second;
  // S3: divide by 400 as shift by 4 then reciprocal of 25
  logic [55:0]        yt_prod;
  logic               s3_neg;
  logic [DAYN_W-1:0]  s3_yt;
  logic [MTERM_W-1:0] s3_mterm;
  logic [DAY_W-1:0]   s3_dd;
  logic [HOUR_W-1:0]  s3_hour;
  logic [MIN_W-1:0]   s3_minute;
  logic [SEC_W-1:0]   s3_second;
  // S4..S7: day number, then extend by unit
  logic [DAYN_W-1:0]  s4_v;
  logic [HOUR_W-1:0]  s4_hour;
  logic [MIN_W-1:0]   s4_minute;
  logic [SEC_W-1:0]   s4_second;
  logic [TICK_W-1:0]  s5_t;
  logic [MIN_W-1:0]   s5_minute;
  logic [SEC_W-1:0]   s5_second;
  logic [TICK_W-1:0]  s6_t;
  logic [SEC_W-1:0]   s6_second;
  logic [TICK_W-1:0]  s7_t;

  assign month_lo = (stamp.month <= MONTH_W'(2));
  assign yt_prod  = 56'(s2_n[31:4]) * 56'(RECIP_25);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg    <= month_lo && (stamp.year == '0);
      s1_yy     <= month_lo ? stamp.year - YEAR_W'(1) : stamp.year;
      s1_mterm  <= MONTH_TERM[stamp.month];
      s1_dd     <= (stamp.day == '0) ? DAY_W'(1) : stamp.day;
      s1_hour   <= stamp.hour;
      s1_minute <= stamp.minute;
      s1_second <= stamp.second;

      s2_neg    <= s1_neg;
      s2_n      <= 32'(s1_yy) * YEAR_MULT;
      s2_mterm  <= s1_mterm;
      s2_dd     <= s1_dd;
      s2_hour   <= s1_hour;
      s2_minute <= s1_minute;
      s2_second <= s1_second;

      s3_neg    <= s2_neg;
      s3_yt     <= s2_neg ? '0 : yt_prod[RECIP_SHIFT +: DAYN_W];
      s3_mterm  <= s2_mterm;
      s3_dd     <= s2_dd;
      s3_hour   <= s2_hour;
      s3_minute <= s2_minute;
      s3_second <= s2_second;

      // year term of -1 is -366; sum stays positive
      s4_v      <= s3_yt + DAYN_W'(s3_mterm) + DAYN_W'(s3_dd)
                   - (s3_neg ? YT_NEG_ONE : '0);
      s4_hour   <= s3_hour;
      s4_minute <= s3_minute;
      s4_second <= s3_second;

      s5_t      <= (unit != UNIT_DAY)
                   ? TICK_W'(s4_v) * HOURS_PER_DAY + TICK_W'(s4_hour)
                   : TICK_W'(s4_v);
      s5_minute <= s4_minute;
      s5_second <= s4_second;

      s6_t      <= (unit == UNIT_SEC || unit == UNIT_MIN)
                   ? s5_t * MINS_PER_HOUR + TICK_W'(s5_minute)
                   : s5_t;
      s6_second <= s5_second;

      s7_t      <= (unit == UNIT_SEC)
                   ? s6_t * SECS_PER_MINUTE + TICK_W'(s6_second)
                   : s6_t;
    end
  end

  assign ticks = s7_t;

endmodule

>>> hw/rtl/dtc_div.sv
module dtc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic                              in_neg,
  input  logic [dtc_pkg::COUNT_W-1:0]       in_mag,
  input  logic [dtc_pkg::DIV_W-1:0]         dv,
  output logic                              out_valid,
  output logic signed [dtc_pkg::COUNT_W-1:0] out_quot
);
  import dtc_pkg::*;

  // one restoring step (one quotient bit) per stage
  logic                 vld [1:COUNT_W];
  logic                 neg [1:COUNT_W];
  logic [COUNT_W-1:0]   acc [1:COUNT_W];
  logic [DIV_W-1:0]     rem [1:COUNT_W];

  for (genvar g = 0; g < COUNT_W; g++) begin : g_step
    logic               v_in;
    logic               n_in;
    logic [COUNT_W-1:0] a_in;
    logic [DIV_W-1:0]   r_in;
    logic [DIV_W:0]     r_ext;
    logic [DIV_W+1:0]   trial;
    logic               ge;

    if (g == 0) begin : g_src_in
      assign v_in = in_valid;
      assign n_in = in_neg;
      assign a_in = in_mag;
      assign r_in = '0;
    end else begin : g_src_stage
      assign v_in = vld[g];
      assign n_in = neg[g];
      assign a_in = acc[g];
      assign r_in = rem[g];
    end

    assign r_ext = {r_in, a_in[COUNT_W-1]};
    assign trial = {1'b0, r_ext} - {2'b00, dv};
    assign ge    = !trial[DIV_W+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg[g+1] <= n_in;
        acc[g+1] <= {a_in[COUNT_W-2:0], ge};
        rem[g+1] <= ge ? trial[DIV_W-1:0] : r_ext[DIV_W-1:0];
      end
    end
  end

  assign out_valid = vld[COUNT_W];
  assign out_quot  = neg[COUNT_W] ? -$signed(acc[COUNT_W]) : $signed(acc[COUNT_W]);

endmodule

>>> hw/rtl/date_to_tick_count_core.sv
// Takes one word per cycle while the output queue has room; the 40-stage divider
// (one quotient bit per stage) sets the pipeline depth.
// A two-word output queue decouples the sides; input stalls only when it is full or in reset.
// Reset (rst, synchronous, active high) empties the pipeline and queue and loads
// unit = day, divisor = 1, start = 1970-01-01 00:00:00.
module date_to_tick_count_core (
  input  logic                               clk,
  input  logic                               rst,
  // input word
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dtc_pkg::YEAR_W-1:0]         year,
  input  logic [dtc_pkg::MONTH_W-1:0]        month,
  input  logic [dtc_pkg::DAY_W-1:0]          day,
  input  logic [dtc_pkg::HOUR_W-1:0]         hour,
  input  logic [dtc_pkg::MIN_W-1:0]          minute,
  input  logic [dtc_pkg::SEC_W-1:0]          second,
  // result word
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dtc_pkg::COUNT_W-1:0] count,
  // register writes
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_index,
  input  logic [dtc_pkg::DIV_W-1:0]          cfg_wdata
);
  import dtc_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. A zero divisor is stored as 1 so the divider
  // never sees zero.
  // ---------------------------------------------------------------------------
  unit_t             unit;
  logic [DIV_W-1:0]  divisor;
  stamp_t            start;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit         <= UNIT_DAY;
      divisor      <= DIV_W'(1);
      start.year   <= YEAR_W'(1970);
      start.month  <= MONTH_W'(1);
      start.day    <= DAY_W'(1);
      start.hour   <= '0;
      start.minute <= '0;
      start.second <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UNIT:         unit         <= unit_t'(cfg_wdata[1:0]);
        REG_DIVISOR:      divisor      <= (cfg_wdata == '0) ? DIV_W'(1) : cfg_wdata;
        REG_START_YEAR:   start.year   <= cfg_wdata[YEAR_W-1:0];
        REG_START_MONTH:  start.month  <= cfg_wdata[MONTH_W-1:0];
        REG_START_DAY:    start.day    <= cfg_wdata[DAY_W-1:0];
        REG_START_HOUR:   start.hour   <= cfg_wdata[HOUR_W-1:0];
        REG_START_MINUTE: start.minute <= cfg_wdata[MIN_W-1:0];
        REG_START_SECOND: start.second <= cfg_wdata[SEC_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance. Every stage moves when the output queue has room; the
  // enable comes from a register so out_ready never reaches in_ready.
  // in_ready is held low during reset so no word is taken and then dropped.
  // ---------------------------------------------------------------------------
  logic [1:0] qcount;
  logic       en;

  assign en       = (qcount != 2'd2);
  assign in_ready = en && !rst;

  // valid bits for S1..S9 (tick pipelines, difference, magnitude)
  logic [9:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[8:1], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // S1..S7: tick count of the input word and of the start stamp. The start
  // runs through an identical pipeline so both arrive together; the user must change
  // the registers only while the block is idle, which the block itself does not enforce.
  // ---------------------------------------------------------------------------
  stamp_t            in_stamp;
  logic [TICK_W-1:0] ticks_in;
  logic [TICK_W-1:0] ticks_start;

  assign in_stamp = '{year: year, month: month, day: day,
                      hour: hour, minute: minute, second: second};

  dtc_ticks u_ticks_in (
    .clk   (clk),
    .en    (en),
    .unit  (unit),
    .stamp (in_stamp),
    .ticks (ticks_in)
  );

  dtc_ticks u_ticks_start (
    .clk   (clk),
    .en    (en),
    .unit  (unit),
    .stamp (start),
    .ticks (ticks_start)
  );

  // ---------------------------------------------------------------------------
  // S8: signed difference. S9: sign and magnitude for the divider.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] s8_diff;
  logic               s9_neg;
  logic [COUNT_W-1:0] s9_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_diff <= {1'b0, ticks_in} - {1'b0, ticks_start};
      s9_neg  <= s8_diff[COUNT_W-1];
      s9_mag  <= s8_diff[COUNT_W-1] ? -s8_diff : s8_diff;
    end
  end

  // ---------------------------------------------------------------------------
  // S10..S49: unsigned restoring divider, sign reapplied at its output, which
  // truncates toward zero.
  // ---------------------------------------------------------------------------
  logic                      div_valid;
  logic signed [COUNT_W-1:0] div_quot;

  dtc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld[9]),
    .in_neg    (s9_neg),
    .in_mag    (s9_mag),
    .dv        (divisor),
    .out_valid (div_valid),
    .out_quot  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Output queue: two words, head drives the port.
  // ---------------------------------------------------------------------------
  logic signed [COUNT_W-1:0] q0;
  logic signed [COUNT_W-1:0] q1;
  logic                      push;
  logic                      pop;

  assign push = en && div_valid;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      qcount <= '0;
    end else begin
      qcount <= qcount + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0 <= (push && qcount == 2'd1) ? div_quot : q1;
    end else if (push && qcount == 2'd0) begin
      q0 <= div_quot;
    end
    if (push && !pop && qcount == 2'd1) begin
      q1 <= div_quot;
    end
  end

  assign out_valid = (qcount != 2'd0);
  assign count     = q0;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_qcount_range: assert property (@(posedge clk) disable iff (rst)
    qcount != 2'd3)
    else $error("output queue count out of range");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[1])
    else $error("accepted word did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!en && !pop) |=> ($stable(div_valid) && $stable(qcount)))
    else $error("pipeline moved while stalled");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (qcount == $past(qcount) - 2'd1))
    else $error("queue count wrong after pop");

endmodule
